// File: hw/rtl/hermite_coefficient_generator_assert.svh
// ----------------------------------------------------------------------------
// hermite coefficient generator assertion macros
// clocked assertion shorthands for the checker, same-cycle and next-cycle
// ----------------------------------------------------------------------------
`ifndef HERMITE_COEFFICIENT_GENERATOR_ASSERT_SVH
`define HERMITE_COEFFICIENT_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define HCG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcg assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define HCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcg assertion failed");

`endif

// File: hw/rtl/hcg_pkg.sv
// ----------------------------------------------------------------------------
// hcg_pkg
// shared widths, limits and state encoding of the hermite coefficient generator
// ----------------------------------------------------------------------------
package hcg_pkg;

  localparam int unsigned MaxRank = 20;
  localparam int unsigned RankW   = 8;
  localparam int unsigned RowW    = 48;
  localparam int unsigned CoefW   = 49;
  localparam int unsigned DegW    = 5;

  typedef enum logic [2:0] {
    StIdle,
    StInit0,
    StInit1,
    StRun,
    StDrain,
    StEmitRd,
    StEmitOut
  } hcg_state_e;

endpackage

// File: hw/rtl/hcg_if.sv
// ----------------------------------------------------------------------------
// hcg channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface hcg_req_if import hcg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [RankW-1:0] rank;

  modport source (output valid, func, rank, input ready);
  modport sink   (input valid, func, rank, output ready);
endinterface

interface hcg_rsp_if import hcg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CoefW-1:0] coefficient;
  logic [DegW-1:0]         degree;
  logic                    last;
  logic                    clamped;

  modport source (output valid, coefficient, degree, last, clamped, input ready);
  modport sink   (input valid, coefficient, degree, last, clamped, output ready);
endinterface

// File: hw/rtl/hermite_coefficient_generator.sv
// ----------------------------------------------------------------------------
// hermite coefficient generator
// builds the integer coefficient row of a hermite polynomial (probabilists'
// or physicists') by the three-term recurrence over two row memories, then
// streams the coefficients from degree 0 up to the rank
// ----------------------------------------------------------------------------
//   channel  dir  beat                                   handshake
//   req_i    in   func, rank                             valid/ready
//   rsp_o    out  coefficient, degree, last, clamped     valid/ready
//
// one request at a time; r is the rank after clamping to MAX_RANK
// steps: accept, init (StInit0, StInit1), recurrence and drain (r >= 2 only),
//   then a read and an output for each result beat (r+1 beats)
// the recurrence issues one row-memory read pair per cycle, pace set by the
//   single read port of each row memory
// reset leaves row memories unwritten; every request rewrites what it reads
// a stalled result beat holds the block; no new request until the last beat
// ----------------------------------------------------------------------------
module hermite_coefficient_generator import hcg_pkg::*; #(
  parameter int unsigned MAX_RANK = MaxRank
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcg_req_if.sink    req_i,
  hcg_rsp_if.source  rsp_o
);

  localparam int unsigned Depth = MAX_RANK + 1;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned BW    = IdxW + 1;

  hcg_state_e state_q, state_d;

  logic            phys_q, phys_d;
  logic            clamp_q, clamp_d;
  logic [IdxW-1:0] rank_q, rank_d;
  logic [IdxW-1:0] n_q, n_d;
  logic [IdxW-1:0] k_q, k_d;
  logic [IdxW-1:0] nm1;

  logic            rd_vld_q, rd_vld_d;
  logic            rd_top_q, rd_top_d;
  logic            rd_zero_q, rd_zero_d;
  logic [IdxW-1:0] rd_k_q, rd_k_d;
  logic [BW-1:0]   rd_b_q, rd_b_d;
  logic [RowW-1:0] hold_q, hold_d;

  logic [RowW-1:0] older_mem [Depth];
  logic [RowW-1:0] newer_mem [Depth];
  logic [RowW-1:0] older_rd_q, newer_rd_q;

  logic            older_we, newer_we, older_re, newer_re;
  logic [IdxW-1:0] older_wa, newer_wa, older_ra, newer_ra;
  logic [RowW-1:0] older_wd, newer_wd;

  logic [RowW-1:0] lo, ol, scaled, prod, upd, src;

  // row memories
  always_ff @(posedge clk_i) begin
    if (older_we) older_mem[older_wa] <= older_wd;
    if (older_re) older_rd_q <= older_mem[older_ra];
  end

  always_ff @(posedge clk_i) begin
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    if (newer_re) newer_rd_q <= newer_mem[newer_ra];
  end

  // recurrence update: a*H(n-1)[k-1] - b*H(n-2)[k], modulo 2^48
  assign lo     = rd_zero_q ? '0 : newer_rd_q;
  assign ol     = rd_top_q ? '0 : older_rd_q;
  assign scaled = phys_q ? {lo[RowW-2:0], 1'b0} : lo;
  assign prod   = ol * {{(RowW-BW){1'b0}}, rd_b_q};
  assign upd    = scaled - prod;
  assign nm1    = n_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phys_q    <= phys_d;
    clamp_q   <= clamp_d;
    rank_q    <= rank_d;
    n_q       <= n_d;
    k_q       <= k_d;
    rd_top_q  <= rd_top_d;
    rd_zero_q <= rd_zero_d;
    rd_k_q    <= rd_k_d;
    rd_b_q    <= rd_b_d;
    hold_q    <= hold_d;
  end

  always_comb begin
    state_d   = state_q;
    phys_d    = phys_q;
    clamp_d   = clamp_q;
    rank_d    = rank_q;
    n_d       = n_q;
    k_d       = k_q;
    rd_vld_d  = 1'b0;
    rd_top_d  = rd_top_q;
    rd_zero_d = rd_zero_q;
    rd_k_d    = rd_k_q;
    rd_b_d    = rd_b_q;
    hold_d    = hold_q;
    older_re  = 1'b0;
    newer_re  = 1'b0;
    older_ra  = '0;
    newer_ra  = '0;
    older_we  = 1'b0;
    newer_we  = 1'b0;
    older_wa  = '0;
    newer_wa  = '0;
    older_wd  = '0;
    newer_wd  = '0;
    req_i.ready = 1'b0;
    rsp_o.valid = 1'b0;

    // write-back of the update issued last cycle
    if (rd_vld_q) begin
      newer_we = 1'b1;
      newer_wa = rd_k_q;
      newer_wd = upd;
      older_we = 1'b1;
      older_wa = rd_k_q;
      older_wd = rd_top_q ? '0 : hold_q;
      hold_d   = newer_rd_q;
    end

    unique case (state_q)
      StIdle: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          phys_d = req_i.func;
          if (req_i.rank > RankW'(MAX_RANK)) begin
            rank_d  = IdxW'(MAX_RANK);
            clamp_d = 1'b1;
          end else begin
            rank_d  = IdxW'(req_i.rank);
            clamp_d = 1'b0;
          end
          state_d = StInit0;
        end
      end
      StInit0: begin
        older_we = 1'b1;
        older_wa = '0;
        older_wd = RowW'(1);
        newer_we = 1'b1;
        newer_wa = '0;
        newer_wd = '0;
        state_d  = StInit1;
      end
      StInit1: begin
        older_we = 1'b1;
        older_wa = IdxW'(1);
        older_wd = '0;
        newer_we = 1'b1;
        newer_wa = IdxW'(1);
        newer_wd = phys_q ? RowW'(2) : RowW'(1);
        if (rank_q >= IdxW'(2) && rank_q > IdxW'(1)) begin
          n_d     = IdxW'(2);
          k_d     = IdxW'(2);
          state_d = StRun;
        end else begin
          k_d     = '0;
          state_d = StEmitRd;
        end
      end
      StRun: begin
        newer_re  = 1'b1;
        newer_ra  = (k_q == '0) ? '0 : k_q - 1'b1;
        older_re  = 1'b1;
        older_ra  = k_q;
        rd_vld_d  = 1'b1;
        rd_k_d    = k_q;
        rd_top_d  = (k_q == n_q);
        rd_zero_d = (k_q == '0);
        rd_b_d    = phys_q ? {nm1, 1'b0} : {1'b0, nm1};
        if (k_q == '0) begin
          if (n_q == rank_q) begin
            state_d = StDrain;
          end else begin
            n_d = n_q + 1'b1;
            k_d = n_q + 1'b1;
          end
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      StDrain: begin
        k_d     = '0;
        state_d = StEmitRd;
      end
      StEmitRd: begin
        if (rank_q == '0) begin
          older_re = 1'b1;
          older_ra = '0;
        end else begin
          newer_re = 1'b1;
          newer_ra = k_q;
        end
        state_d = StEmitOut;
      end
      StEmitOut: begin
        rsp_o.valid = 1'b1;
        if (rsp_o.ready) begin
          if (k_q == rank_q) begin
            state_d = StIdle;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = StEmitRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign src               = (rank_q == '0) ? older_rd_q : newer_rd_q;
  assign rsp_o.coefficient = {src[RowW-1], src};
  assign rsp_o.degree      = DegW'(k_q);
  assign rsp_o.last        = (k_q == rank_q);
  assign rsp_o.clamped     = clamp_q;

endmodule

// File: hw/rtl/hcg_checker.sv
// ----------------------------------------------------------------------------
// hcg checker
// port-level checks of the hermite coefficient generator, bound to the top
// ----------------------------------------------------------------------------
`include "hermite_coefficient_generator_assert.svh"

module hcg_checker import hcg_pkg::*; #(
  parameter int unsigned MAX_RANK = MaxRank
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic signed [CoefW-1:0] rsp_coefficient_i,
  input logic [DegW-1:0]         rsp_degree_i,
  input logic                    rsp_last_i,
  input logic                    rsp_clamped_i
);

  logic req_beat;
  assign req_beat = req_valid_i && req_ready_i;

  // stalled result beat keeps its payload
  `HCG_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_coefficient_i) && $stable(rsp_degree_i) && $stable(rsp_last_i))

  // no request taken while a result is pending
  `HCG_ASSERT_NOW(a_no_overlap, rsp_valid_i, !req_ready_i && !req_beat)

  // leading coefficient, a power of two, is positive
  `HCG_ASSERT_NOW(a_lead_pos, rsp_valid_i && rsp_last_i, rsp_coefficient_i > 0)

  // clamped request ends at the limit degree
  `HCG_ASSERT_NOW(a_clamp_deg, rsp_valid_i && rsp_last_i && rsp_clamped_i, rsp_degree_i == DegW'(MAX_RANK))

endmodule

bind hermite_coefficient_generator hcg_checker #(
  .MAX_RANK (MAX_RANK)
) u_hcg_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_coefficient_i (rsp_o.coefficient),
  .rsp_degree_i      (rsp_o.degree),
  .rsp_last_i        (rsp_o.last),
  .rsp_clamped_i     (rsp_o.clamped)
);
